// ===== rtl/kti_pkg.sv =====
// Shared types, status codes and controller/datapath command structs for the keyframe interpolator.
package kti_pkg;

    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_SINGLE = 3'd1;
    localparam logic [2:0] ST_LOW    = 3'd2;
    localparam logic [2:0] ST_HIGH   = 3'd3;
    localparam logic [2:0] ST_ZERO   = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;

    localparam logic [1:0] ADDR_ZERO = 2'd0;
    localparam logic [1:0] ADDR_ONE  = 2'd1;
    localparam logic [1:0] ADDR_NEXT = 2'd2;

    localparam logic [1:0] RES_WRITE = 2'd0;
    localparam logic [1:0] RES_RDATA = 2'd1;
    localparam logic [1:0] RES_PREV  = 2'd2;
    localparam logic [1:0] RES_LERP  = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [5:0]  key_index;
        logic [31:0] key_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [31:0] query_time;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [2:0]  status;
    } out_t;

    typedef struct packed {
        logic [31:0] key_time;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } key_t;

    typedef struct packed {
        logic       load_item;
        logic       ram_we;
        logic [1:0] addr_sel;
        logic       idx_clr;
        logic       idx_inc;
        logic       prev_load;
        logic       div_start;
        logic       div_step;
        logic       mul_step;
        logic       res_load;
        logic [1:0] res_src;
        logic [2:0] res_status;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_kind;
        logic n_one;
        logic t_lt_rd;
        logic rd_le_prev;
        logic t_lt_prev;
        logic last;
        logic div_done;
        logic mul_done;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/kti_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module kti_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/kti_dp.sv =====
// Datapath: item and key registers, key store, divider, shared multiplier and output register.
module kti_dp #(
    parameter int MAX_KEYS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  kti_pkg::in_t  in_data,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_wdata,
    input  kti_pkg::cmd_t cmd,
    output kti_pkg::stat_t stat,
    output logic          out_valid,
    input  logic          out_ready,
    output kti_pkg::out_t out_data
);

    localparam int AW = $clog2(MAX_KEYS);

    logic [6:0]   key_count_reg;
    kti_pkg::in_t item_reg;
    kti_pkg::key_t prev_reg, next_reg, rdata;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] raddr, waddr;
    logic          slot_ok;
    logic [31:0]   n_val;
    logic [32:0]   rem_reg, rem_sh;
    logic [31:0]   dt_reg, q_reg;
    logic [5:0]    div_cnt_reg;
    logic [2:0]    mc_reg;
    logic [63:0]   prod_reg;
    logic          neg_reg;
    logic [31:0]   base_reg;
    logic [31:0]   lx_reg, ly_reg, lz_reg;
    logic [31:0]   ca, cb;
    logic signed [32:0] delta;
    logic [31:0]   mag;
    logic [32:0]   sum;
    kti_pkg::out_t res_reg, res_next;
    kti_pkg::out_t out_reg;
    logic          out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= 7'd1;
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (key_count_reg == 7'd0)
        begin
            n_val = 32'd1;
        end
        else if (32'(key_count_reg) > 32'(MAX_KEYS))
        begin
            n_val = 32'(MAX_KEYS);
        end
        else
        begin
            n_val = 32'(key_count_reg);
        end
    end

    assign slot_ok = 32'(item_reg.key_index) < 32'(MAX_KEYS);
    assign waddr   = AW'(32'(item_reg.key_index));

    always_comb
    begin
        case (cmd.addr_sel)
            kti_pkg::ADDR_ZERO: raddr = '0;
            kti_pkg::ADDR_ONE:  raddr = AW'(1);
            kti_pkg::ADDR_NEXT: raddr = AW'(32'(idx_reg) + 32'd2);
            default:            raddr = '0;
        endcase
    end

    kti_ram #(.WIDTH($bits(kti_pkg::key_t)), .DEPTH(MAX_KEYS)) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we && slot_ok),
        .waddr (waddr),
        .wdata ({item_reg.key_time, item_reg.value_x, item_reg.value_y, item_reg.value_z}),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.prev_load)
        begin
            prev_reg <= rdata;
        end
        if (cmd.div_start)
        begin
            next_reg <= rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // Restoring division of (t - t_i) * 2^32 by the interval, one quotient bit a cycle.
    assign rem_sh = {rem_reg[31:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= {1'b0, item_reg.query_time - prev_reg.key_time};
            dt_reg  <= rdata.key_time - prev_reg.key_time;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, dt_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dt_reg};
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end

    // One multiplier shared by the three components: even steps multiply, odd steps add.
    always_comb
    begin
        case (mc_reg[2:1])
            2'd0:    begin ca = prev_reg.x; cb = next_reg.x; end
            2'd1:    begin ca = prev_reg.y; cb = next_reg.y; end
            default: begin ca = prev_reg.z; cb = next_reg.z; end
        endcase
        delta = $signed({cb[31], cb}) - $signed({ca[31], ca});
        mag   = delta[32] ? 32'(-delta) : delta[31:0];
        if (neg_reg)
        begin
            sum = {base_reg[31], base_reg} - {1'b0, prod_reg[63:32]};
        end
        else
        begin
            sum = {base_reg[31], base_reg} + {1'b0, prod_reg[63:32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mc_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            mc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            mc_reg <= mc_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            if (!mc_reg[0])
            begin
                prod_reg <= 64'(mag) * 64'(q_reg);
                neg_reg  <= delta[32];
                base_reg <= ca;
            end
            else
            begin
                case (mc_reg[2:1])
                    2'd0:    lx_reg <= sum[31:0];
                    2'd1:    ly_reg <= sum[31:0];
                    default: lz_reg <= sum[31:0];
                endcase
            end
        end
    end

    always_comb
    begin
        case (cmd.res_src)
            kti_pkg::RES_WRITE: res_next = {96'd0, kti_pkg::ST_WRITE};
            kti_pkg::RES_RDATA: res_next = {rdata.x, rdata.y, rdata.z, cmd.res_status};
            kti_pkg::RES_PREV:  res_next = {prev_reg.x, prev_reg.y, prev_reg.z, cmd.res_status};
            kti_pkg::RES_LERP:  res_next = {lx_reg, ly_reg, lz_reg, kti_pkg::ST_INTERP};
            default:            res_next = {96'd0, kti_pkg::ST_WRITE};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign stat.in_kind    = in_data.kind;
    assign stat.n_one      = (n_val == 32'd1);
    assign stat.t_lt_rd    = item_reg.query_time < rdata.key_time;
    assign stat.rd_le_prev = rdata.key_time <= prev_reg.key_time;
    assign stat.t_lt_prev  = item_reg.query_time < prev_reg.key_time;
    assign stat.last       = (32'(idx_reg) + 32'd2 == n_val);
    assign stat.div_done   = (div_cnt_reg == 6'd32);
    assign stat.mul_done   = (mc_reg == 3'd6);
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== rtl/kti_ctrl.sv =====
// Controller: sequences key writes and, for each query, the key search, the division and the interpolation.
module kti_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  kti_pkg::stat_t stat,
    output kti_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_K0   = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel = kti_pkg::ADDR_ZERO;
        cmd.res_src  = kti_pkg::RES_WRITE;
        cmd.res_status = kti_pkg::ST_WRITE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = (stat.in_kind == kti_pkg::KIND_QUERY) ? S_RD0 : S_WR;
                end
            end
            S_WR:
            begin
                cmd.ram_we   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_src  = kti_pkg::RES_WRITE;
                state_next   = S_EMIT;
            end
            S_RD0:
            begin
                cmd.addr_sel = kti_pkg::ADDR_ZERO;
                state_next   = S_K0;
            end
            S_K0:
            begin
                cmd.prev_load = 1'b1;
                cmd.idx_clr   = 1'b1;
                cmd.addr_sel  = kti_pkg::ADDR_ONE;
                if (stat.n_one || stat.t_lt_rd)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_src    = kti_pkg::RES_RDATA;
                    cmd.res_status = stat.n_one ? kti_pkg::ST_SINGLE : kti_pkg::ST_LOW;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.addr_sel = kti_pkg::ADDR_NEXT;
                if (stat.t_lt_rd)
                begin
                    if (stat.rd_le_prev || stat.t_lt_prev)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_src    = kti_pkg::RES_PREV;
                        cmd.res_status = kti_pkg::ST_ZERO;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else if (stat.last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_src    = kti_pkg::RES_RDATA;
                    cmd.res_status = kti_pkg::ST_HIGH;
                    state_next     = S_EMIT;
                end
                else
                begin
                    // Advance: the key just read becomes the start of the next interval.
                    cmd.prev_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = kti_pkg::RES_LERP;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_query_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && stat.in_kind == kti_pkg::KIND_QUERY)
        |=> state_reg == S_RD0)
        else $error("query word did not start the key read");

    a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_done) |=> (state_reg == S_MUL))
        else $error("division finished without starting interpolation");

    a_emit_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("result not handed to the output register");

    a_out_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten while full");

endmodule

// ===== rtl/keyframe_track_interpolator_core.sv =====
// Top level of the keyframe track interpolator: controller, datapath and key store.
//
//   Channel  Direction  Handshake             Word
//   in       in         in_valid / in_ready   kti_pkg::in_t (key write or query)
//   out      out        out_valid / out_ready kti_pkg::out_t (x, y, z, status)
//   cfg      in         cfg_we                key_count, 7 bits
//
// A key write goes to the key store and result register, then to the output register.
// A query reads key 0 and ends there for a single key or a query time before the first
// key; else it scans the key store for the interval that starts at key i (one key store
// read a cycle), then runs the bit-serial divider and the shared 32x32 multiplier and
// moves the result to the output register; the next word is taken in the idle state.
// One word is worked on at a time; the next is accepted once the result has moved to
// the output register, so a stalled output delays acceptance by the stall.
// Reset clears the controller, the output valid flag and sets key_count to one; the
// key store is not cleared and keys must be written before they are queried.
module keyframe_track_interpolator_core #(
    parameter int MAX_KEYS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kti_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output kti_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_wdata
);

    kti_pkg::cmd_t  cmd;
    kti_pkg::stat_t stat;

    // The controller sees only status flags and in_valid, and drives only commands and in_ready.
    kti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kti_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
